// ===== rtl/csq_pkg.sv =====
// ----------------------------------------------------------------------------
// csq_pkg
// Shared codes and controller/datapath interface types for the counting
// semaphore with wait queue.
// ----------------------------------------------------------------------------
package csq_pkg;

    localparam logic [2:0] ACT_WAIT  = 3'd0;
    localparam logic [2:0] ACT_TIMED = 3'd1;
    localparam logic [2:0] ACT_TRY   = 3'd2;
    localparam logic [2:0] ACT_SIG   = 3'd3;
    localparam logic [2:0] ACT_TICK  = 3'd4;
    localparam logic [2:0] ACT_CLOSE = 3'd5;

    localparam logic [2:0] ST_GRANTED = 3'd0;
    localparam logic [2:0] ST_BUSY    = 3'd1;
    localparam logic [2:0] ST_PARKED  = 3'd2;
    localparam logic [2:0] ST_WOKEN   = 3'd3;
    localparam logic [2:0] ST_CLOSED  = 3'd4;
    localparam logic [2:0] ST_TIMEOUT = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;

    localparam int COUNT_W = 18;
    localparam logic signed [COUNT_W-1:0] COUNT_TOP = 18'sh1FFFF;
    localparam logic signed [COUNT_W-1:0] COUNT_ONE = 18'sd1;

    typedef struct packed {
        logic op;          // wait, timed wait or try wait on the input fields
        logic sig_inc;     // signal: return one unit
        logic sig_step;    // signal: retire the head entry
        logic sig_emit;    // signal: present the woken thread
        logic scan_start;  // tick or close: rewind the scan pointer
        logic scan_issue;  // tick or close: read the next entry
        logic flush;       // end of scan: release held result; close also reloads count and clears queue
    } t_cmd;

    typedef struct packed {
        logic count_pos;
        logic occ_zero;
        logic head_live;
        logic scan_more;
    } t_sts;

endpackage

// ===== rtl/csq_ctrl.sv =====
// ----------------------------------------------------------------------------
// csq_ctrl
// Sequencer: decodes accepted commands and steps the datapath through
// signal and scan operations.
// ----------------------------------------------------------------------------
module csq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_action,
    input  csq_pkg::t_sts i_sts,
    output csq_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import csq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SIG   = 3'd1;
    localparam logic [2:0] S_SOUT  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_FLUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_action)
                        ACT_WAIT, ACT_TIMED, ACT_TRY: begin
                            o_cmd.op = 1'b1;
                        end
                        ACT_SIG: begin
                            o_cmd.sig_inc = 1'b1;
                            n_state = S_SIG;
                        end
                        ACT_TICK, ACT_CLOSE: begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SIG: begin
                if (i_sts.count_pos || i_sts.occ_zero) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sig_step = 1'b1;
                    if (i_sts.head_live) begin
                        n_state = S_SOUT;
                    end
                end
            end
            S_SOUT: begin
                o_cmd.sig_emit = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                if (i_sts.scan_more) begin
                    o_cmd.scan_issue = 1'b1;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/csq_dp.sv =====
// ----------------------------------------------------------------------------
// csq_dp
// Datapath: count, circular waiter queue (ids and deadlines in memory,
// pending flags in flops), scan stage and result register.
// ----------------------------------------------------------------------------
module csq_dp #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  csq_pkg::t_cmd i_cmd,
    output csq_pkg::t_sts o_sts,
    input  logic [2:0]    i_action,
    input  logic [7:0]    i_thread_id,
    input  logic [15:0]   i_timeout_ticks,
    input  logic          i_cfg_wr_en,
    input  logic [15:0]   i_cfg_wr_data,
    output logic          o_result_valid,
    output logic [7:0]    o_thread_id_out,
    output logic [2:0]    o_status,
    output logic          o_last
);
    import csq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = THREAD_ID_BITS;

    logic [IW-1:0] mem_id [QUEUE_DEPTH];
    logic [15:0]   mem_dl [QUEUE_DEPTH];

    logic [15:0]              r_init;
    logic signed [COUNT_W-1:0] r_count;
    logic [QUEUE_DEPTH-1:0]   r_pend;
    logic [AW-1:0]            r_head;
    logic [OW-1:0]            r_occ;
    logic [OW-1:0]            r_scan_i;
    logic [AW-1:0]            r_scan_slot;
    logic                     r_mode_tick;
    logic                     r_s_vld;
    logic [AW-1:0]            r_s_slot;
    logic [IW-1:0]            r_rd_id;
    logic [15:0]              r_rd_dl;
    logic                     r_hold_vld;
    logic [7:0]               r_hold_id;
    logic [2:0]               r_hold_st;
    logic                     r_out_vld;
    logic [7:0]               r_out_id;
    logic [2:0]               r_out_st;
    logic                     r_out_last;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    logic          count_pos;
    logic          full;
    logic [OW:0]   slot_sum;
    logic [AW-1:0] park_slot;
    logic [IW-1:0] in_id;
    logic          is_try;
    logic          park_we;
    logic [2:0]    op_st;
    logic          head_live;
    logic          pend_s;
    logic          tick_we;
    logic          tick_hit;
    logic          close_hit;
    logic          push;
    logic [2:0]    push_st;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] dl_waddr;
    logic [15:0]   dl_wdata;

    assign count_pos = !r_count[COUNT_W-1] && (r_count != '0);
    assign full      = (r_occ == OW'(QUEUE_DEPTH));
    assign slot_sum  = {1'b0, OW'(r_head)} + {1'b0, r_occ};
    assign park_slot = (slot_sum >= (OW+1)'(QUEUE_DEPTH))
                       ? AW'(slot_sum - (OW+1)'(QUEUE_DEPTH)) : AW'(slot_sum);
    assign in_id     = IW'(i_thread_id);
    assign is_try    = (i_action == ACT_TRY);
    assign park_we   = i_cmd.op && !is_try && !count_pos && !full;

    always_comb begin
        if (count_pos) begin
            op_st = ST_GRANTED;
        end else if (is_try) begin
            op_st = ST_BUSY;
        end else if (full) begin
            op_st = ST_FULL;
        end else begin
            op_st = ST_PARKED;
        end
    end

    assign head_live = r_pend[r_head];
    assign pend_s    = r_pend[r_s_slot];
    assign tick_we   = r_s_vld && r_mode_tick && pend_s && (r_rd_dl != 16'd0);
    assign tick_hit  = tick_we && (r_rd_dl == 16'd1);
    assign close_hit = r_s_vld && !r_mode_tick && pend_s;
    assign push      = tick_hit || close_hit;
    assign push_st   = tick_hit ? ST_TIMEOUT : ST_CLOSED;

    assign rd_addr   = i_cmd.scan_issue ? r_scan_slot : r_head;
    assign dl_waddr  = park_we ? park_slot : r_s_slot;
    assign dl_wdata  = park_we ? ((i_action == ACT_TIMED) ? i_timeout_ticks : 16'd0)
                               : r_rd_dl - 16'd1;

    always_ff @(posedge i_clk) begin
        if (park_we) begin
            mem_id[park_slot] <= in_id;
        end
        r_rd_id <= mem_id[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (park_we || tick_we) begin
            mem_dl[dl_waddr] <= dl_wdata;
        end
        r_rd_dl <= mem_dl[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= '0;
            r_count    <= '0;
            r_pend     <= '0;
            r_head     <= '0;
            r_occ      <= '0;
            r_s_vld    <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.op || i_cmd.sig_emit
                         || ((push || i_cmd.flush) && r_hold_vld);
            r_s_vld   <= i_cmd.scan_issue;
            if (i_cfg_wr_en) begin
                r_init <= i_cfg_wr_data;
            end

            if (i_cmd.op) begin
                if (count_pos || park_we) begin
                    r_count <= r_count - COUNT_ONE;
                end
                if (park_we) begin
                    r_pend[park_slot] <= 1'b1;
                    r_occ <= r_occ + 1'b1;
                end
                r_out_id   <= 8'(in_id);
                r_out_st   <= op_st;
                r_out_last <= 1'b1;
            end

            if (i_cmd.sig_inc && (r_count != COUNT_TOP)) begin
                r_count <= r_count + COUNT_ONE;
            end

            if (i_cmd.sig_step) begin
                r_pend[r_head] <= 1'b0;
                r_head <= wrap_inc(r_head);
                r_occ  <= r_occ - 1'b1;
                if (!head_live) begin
                    r_count <= r_count + COUNT_ONE;
                end
            end

            if (i_cmd.sig_emit) begin
                r_out_id   <= 8'(r_rd_id);
                r_out_st   <= ST_WOKEN;
                r_out_last <= 1'b1;
            end

            if (i_cmd.scan_start) begin
                r_scan_i    <= '0;
                r_scan_slot <= r_head;
                r_mode_tick <= (i_action == ACT_TICK);
            end

            if (i_cmd.scan_issue) begin
                r_s_slot    <= r_scan_slot;
                r_scan_slot <= wrap_inc(r_scan_slot);
                r_scan_i    <= r_scan_i + 1'b1;
            end

            if (tick_hit) begin
                r_pend[r_s_slot] <= 1'b0;
            end

            if (push) begin
                if (r_hold_vld) begin
                    r_out_id   <= r_hold_id;
                    r_out_st   <= r_hold_st;
                    r_out_last <= 1'b0;
                end
                r_hold_vld <= 1'b1;
                r_hold_id  <= 8'(r_rd_id);
                r_hold_st  <= push_st;
            end

            if (i_cmd.flush) begin
                if (r_hold_vld) begin
                    r_out_id   <= r_hold_id;
                    r_out_st   <= r_hold_st;
                    r_out_last <= 1'b1;
                end
                r_hold_vld <= 1'b0;
                if (!r_mode_tick) begin
                    r_count <= signed'({2'b00, r_init});
                    r_pend  <= '0;
                    r_head  <= '0;
                    r_occ   <= '0;
                end
            end
        end
    end

    assign o_sts.count_pos = count_pos;
    assign o_sts.occ_zero  = (r_occ == '0);
    assign o_sts.head_live = head_live;
    assign o_sts.scan_more = (r_scan_i < r_occ);

    assign o_result_valid  = r_out_vld;
    assign o_thread_id_out = r_out_id;
    assign o_status        = r_out_st;
    assign o_last          = r_out_last;

endmodule

// ===== rtl/counting_semaphore_wait_queue.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue
// Counting semaphore with a FIFO of waiting thread ids and tick deadlines.
//
//   channel   signals                                         transfer
//   command   i_start, i_action, i_thread_id, i_timeout_ticks  i_start && !o_busy
//   config    i_cfg_wr_en, i_cfg_wr_data                       i_cfg_wr_en
//   result    o_result_valid, o_thread_id_out, o_status, o_last  o_result_valid
//
// Wait, timed wait and try wait: never go busy, result the next cycle.
// Signal: busy while queue entries at the head pointer are retired, one per
// cycle, at most QUEUE_DEPTH; a woken waiter shows as busy falls.
// Tick and close: busy while each queue entry is read from the id and deadline
// memories, one per cycle, then a flush; the last result shows as busy falls.
// Reset clears the queue at once; results are strobes and are never stalled.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue #(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_thread_id,
    input  logic [15:0] i_timeout_ticks,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    output logic        o_result_valid,
    output logic [7:0]  o_thread_id_out,
    output logic [2:0]  o_status,
    output logic        o_last
);
    import csq_pkg::*;

    t_cmd cmd;
    t_sts sts;

    csq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_action (i_action),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    csq_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_action),
        .i_thread_id     (i_thread_id),
        .i_timeout_ticks (i_timeout_ticks),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_result_valid  (o_result_valid),
        .o_thread_id_out (o_thread_id_out),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    a_step_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sig_step |-> !sts.occ_zero)
        else $error("signal retired an entry from an empty queue");

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.scan_issue |-> sts.scan_more)
        else $error("scan read past occupancy");

    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.flush |=> !o_busy)
        else $error("busy after scan flush");

    a_wake_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sig_emit |=> (o_result_valid && o_last && (o_status == ST_WOKEN)))
        else $error("woken waiter not reported");

endmodule

// ===== tb/sv/tb_counting_semaphore_wait_queue.sv =====
// ----------------------------------------------------------------------------
// tb_counting_semaphore_wait_queue
// Self-checking bench for the counting semaphore with wait queue. A driver
// feeds semaphore operations from a queue in random bursts. A monitor
// predicts the grant, busy, full, park, wake, timeout and close reports of
// every accepted operation and holds each result strobe to them in order.
// ----------------------------------------------------------------------------
module tb_counting_semaphore_wait_queue;

    import csq_pkg::*;

    localparam int QDEPTH        = 16;
    localparam int SETTLE_CYCLES = 2 * QDEPTH + 10;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  tid;
        logic [15:0] ticks;
    } t_sem_req;

    typedef struct packed {
        logic [7:0] tid;
        logic [2:0] status;
        logic       last;
    } t_sem_result;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_start         = 1'b0;
    logic [2:0]  i_action        = '0;
    logic [7:0]  i_thread_id     = '0;
    logic [15:0] i_timeout_ticks = '0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [15:0] i_cfg_wr_data   = '0;
    logic        o_busy;
    logic        o_result_valid;
    logic [7:0]  o_thread_id_out;
    logic [2:0]  o_status;
    logic        o_last;

    counting_semaphore_wait_queue #(
        .QUEUE_DEPTH   (QDEPTH),
        .THREAD_ID_BITS(8)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_action       (i_action),
        .i_thread_id    (i_thread_id),
        .i_timeout_ticks(i_timeout_ticks),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .o_result_valid (o_result_valid),
        .o_thread_id_out(o_thread_id_out),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predicted semaphore state
    logic [15:0]              init_count;
    logic signed [COUNT_W-1:0] sem_count;
    logic [7:0]               wq_id       [QDEPTH];
    logic                     wq_pending  [QDEPTH];
    logic [15:0]              wq_deadline [QDEPTH];
    logic [3:0]               wq_head;
    logic [4:0]               wq_occ;

    t_sem_req    req_queue[$];
    t_sem_result expected_results[$];

    int   n_sent     = 0;
    int   n_accepted = 0;
    int   err_count  = 0;
    int   gap_left   = 0;
    int   burst_left = 4;
    logic cmd_taken  = 1'b0;

    function automatic t_sem_result make_result(input logic [7:0] tid, input logic [2:0] st);
        t_sem_result r;
        r.tid    = tid;
        r.status = st;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic clear_waiters();
        sem_count = $signed({2'b00, init_count});
        for (int i = 0; i < QDEPTH; i++) begin
            wq_pending[i]  = 1'b0;
            wq_id[i]       = '0;
            wq_deadline[i] = '0;
        end
        wq_head = '0;
        wq_occ  = '0;
    endtask

    task automatic predict_semaphore(input t_sem_req req);
        t_sem_result outs[$];
        t_sem_result r;
        logic [3:0]  slot;
        logic        live;
        bit          woke;
        case (req.action)
            ACT_WAIT, ACT_TIMED, ACT_TRY: begin
                if (sem_count > 0) begin
                    sem_count = sem_count - COUNT_ONE;
                    outs.push_back(make_result(req.tid, ST_GRANTED));
                end else if (req.action == ACT_TRY) begin
                    outs.push_back(make_result(req.tid, ST_BUSY));
                end else if (wq_occ >= QDEPTH) begin
                    outs.push_back(make_result(req.tid, ST_FULL));
                end else begin
                    slot = wq_head + wq_occ[3:0];
                    sem_count = sem_count - COUNT_ONE;
                    wq_id[slot]       = req.tid;
                    wq_pending[slot]  = 1'b1;
                    wq_deadline[slot] = (req.action == ACT_TIMED) ? req.ticks : 16'd0;
                    wq_occ = wq_occ + 5'd1;
                    outs.push_back(make_result(req.tid, ST_PARKED));
                end
            end
            ACT_SIG: begin
                if (sem_count < COUNT_TOP) sem_count = sem_count + COUNT_ONE;
                if (sem_count <= 0) begin
                    woke = 1'b0;
                    while (wq_occ > 0 && !woke) begin
                        slot = wq_head;
                        live = wq_pending[slot];
                        wq_pending[slot] = 1'b0;
                        wq_head = wq_head + 4'd1;
                        wq_occ  = wq_occ - 5'd1;
                        if (live) begin
                            outs.push_back(make_result(wq_id[slot], ST_WOKEN));
                            woke = 1'b1;
                        end else begin
                            sem_count = sem_count + COUNT_ONE;
                        end
                    end
                end
            end
            ACT_TICK: begin
                for (int i = 0; i < wq_occ; i++) begin
                    slot = wq_head + i[3:0];
                    if (wq_pending[slot] && wq_deadline[slot] != 16'd0) begin
                        wq_deadline[slot] = wq_deadline[slot] - 16'd1;
                        if (wq_deadline[slot] == 16'd0) begin
                            wq_pending[slot] = 1'b0;
                            outs.push_back(make_result(wq_id[slot], ST_TIMEOUT));
                        end
                    end
                end
            end
            ACT_CLOSE: begin
                for (int i = 0; i < wq_occ; i++) begin
                    slot = wq_head + i[3:0];
                    if (wq_pending[slot]) outs.push_back(make_result(wq_id[slot], ST_CLOSED));
                end
                clear_waiters();
            end
            default: begin
            end
        endcase
        for (int k = 0; k < outs.size(); k++) begin
            r = outs[k];
            r.last = (k == outs.size() - 1);
            expected_results.push_back(r);
        end
    endtask

    // monitor: prediction on command transfer, checking on result strobe
    always @(posedge i_clk) begin : monitor
        t_sem_result want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            cmd_taken <= i_start && !o_busy;
            if (i_start && !o_busy) begin
                predict_semaphore('{i_action, i_thread_id, i_timeout_ticks});
                n_accepted++;
            end
            if (o_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: thread_id_out %0d status %0d last %0d",
                           o_thread_id_out, o_status, o_last);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_thread_id_out !== want.tid) begin
                        $error("thread_id_out: expected %0d, actual %0d",
                               want.tid, o_thread_id_out);
                        err_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        err_count++;
                    end
                    if (o_last !== want.last) begin
                        $error("last: expected %0d, actual %0d", want.last, o_last);
                        err_count++;
                    end
                end
            end
        end
    end

    // driver: bursts of commands with random gaps
    always @(negedge i_clk) begin : driver
        t_sem_req req;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (!i_start || cmd_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_start <= 1'b0;
            end else if (req_queue.size() != 0) begin
                req = req_queue.pop_front();
                i_action        <= req.action;
                i_thread_id     <= req.tid;
                i_timeout_ticks <= req.ticks;
                i_start         <= 1'b1;
                n_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    task automatic push_req(input logic [2:0] act, input logic [7:0] tid,
                            input logic [15:0] ticks);
        req_queue.push_back('{act, tid, ticks});
    endtask

    task automatic wait_idle();
        while (req_queue.size() != 0 || n_accepted != n_sent ||
               expected_results.size() != 0 || o_busy)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_init_count(input logic [15:0] value);
        i_cfg_wr_data <= value;
        i_cfg_wr_en   <= 1'b1;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        init_count = value;
    endtask

    task automatic push_random(input int n);
        int          pick;
        logic [2:0]  act;
        logic [15:0] ticks;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if      (pick < 22) act = ACT_WAIT;
            else if (pick < 50) act = ACT_TIMED;
            else if (pick < 60) act = ACT_TRY;
            else if (pick < 80) act = ACT_SIG;
            else if (pick < 95) act = ACT_TICK;
            else if (pick < 98) act = ACT_CLOSE;
            else                act = 3'($urandom_range(6, 7));
            if (act == ACT_TIMED && $urandom_range(0, 4) != 0)
                ticks = 16'($urandom_range(1, 6));
            else
                ticks = 16'($urandom_range(1, 65535));
            push_req(act, 8'($urandom_range(0, 255)), ticks);
        end
    endtask

    task automatic run_phase(input logic [15:0] start_count, input int n);
        write_init_count(start_count);
        push_req(ACT_CLOSE, 8'd0, 16'd1);
        push_random(n);
        wait_idle();
    endtask

    initial begin
        init_count = '0;
        clear_waiters();
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: count starts at zero
        push_req(ACT_TRY, 8'd0, 16'd1);
        push_req(ACT_TIMED, 8'd255, 16'd1);
        push_req(ACT_TICK, 8'd0, 16'd1);
        push_req(ACT_SIG, 8'd0, 16'd1);        // drops the expired entry
        push_req(ACT_TRY, 8'h55, 16'd1);
        push_req(ACT_TIMED, 8'd0, 16'd0);      // zero ticks: plain wait
        for (int k = 1; k < QDEPTH; k++)
            push_req((k % 2) ? ACT_TIMED : ACT_WAIT, 8'(k * 17), 16'hFFFF);
        push_req(ACT_WAIT, 8'hAA, 16'd1);      // queue full
        push_req(ACT_TICK, 8'd0, 16'd1);
        push_req(ACT_SIG, 8'd0, 16'd1);
        push_req(3'd6, 8'hFF, 16'hFFFF);
        push_req(3'd7, 8'h00, 16'h0000);
        push_req(ACT_CLOSE, 8'd0, 16'd1);
        push_req(ACT_SIG, 8'd0, 16'd1);
        push_req(ACT_TICK, 8'd0, 16'd1);
        push_req(ACT_CLOSE, 8'd0, 16'd1);
        wait_idle();

        run_phase(16'd0, 40);
        run_phase(16'd2, 35);
        run_phase(16'd1, 30);
        run_phase(16'hFFFF, 15);
        run_phase(16'($urandom_range(0, 4)), 20);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
